// File: rtl/core/ece_pkg.sv
// ece_pkg: types, constants and sizes shared by the encoder count extender
// depends on: nothing
`default_nettype none

package ece_pkg;

    localparam int ECE_AXES_DEFAULT = 8;          // axes with state storage
    localparam int ECE_AXES_MAX     = 16;
    localparam int ECE_AXIS_W       = 3;
    localparam int ECE_RAW_W        = 24;
    localparam int ECE_HIGH_W       = 8;
    localparam int ECE_EXT_W        = ECE_HIGH_W + ECE_RAW_W;
    localparam int ECE_CFG_W        = 4;
    localparam int ECE_CMP_W        = $clog2(ECE_AXES_MAX + 1);
    localparam logic [ECE_CFG_W-1:0] ECE_AXES_PRESENT_RST = ECE_CFG_W'(8);

    // top two bits of the raw count as seen from the top-bit mask 0xc00000
    localparam logic [1:0] ECE_TOP_LOW  = 2'b00;
    localparam logic [1:0] ECE_TOP_HIGH = 2'b11;

    // request codes
    localparam logic ECE_REQ_READ    = 1'b0;
    localparam logic ECE_REQ_CAPTURE = 1'b1;

    // queue between front and back
    localparam int ECE_Q_DEPTH = 2;
    localparam int ECE_Q_PTR_W = (ECE_Q_DEPTH > 1) ? $clog2(ECE_Q_DEPTH) : 1;
    localparam int ECE_Q_CNT_W = $clog2(ECE_Q_DEPTH + 1);

    typedef struct packed {
        logic                  req_type;
        logic [ECE_AXIS_W-1:0] axis;
        logic [ECE_RAW_W-1:0]  raw_count;
    } ece_in_t;

    typedef struct packed {
        logic signed [ECE_EXT_W-1:0] position;
        logic                        axis_valid;
        logic [ECE_AXIS_W-1:0]       axis_out;
    } ece_out_t;

    // classified item handed from the front to the back
    typedef struct packed {
        logic                  capture;
        logic                  axis_ok;
        logic [ECE_AXIS_W-1:0] axis;
        logic [ECE_RAW_W-1:0]  raw_count;
    } ece_cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } ece_q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ece_front.sv
// ece_front: holds the axes_present register, accepts items and classifies them
// depends on: ece_pkg
`default_nettype none

module ece_front
    import ece_pkg::*;
#(
    parameter int AXES = ECE_AXES_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [ECE_CFG_W-1:0] cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ece_in_t              s_data,
    input  wire ece_q_stat_t          q_stat,
    output logic                      q_wr_en,
    output ece_cmd_t                  q_wr_data
);

    logic [ECE_CFG_W-1:0] axes_present_reg;
    logic [ECE_CMP_W-1:0] axis_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axes_present_reg <= ECE_AXES_PRESENT_RST;
        end else if (cfg_we) begin
            axes_present_reg <= cfg_wdata;
        end
    end

    assign axis_wide = ECE_CMP_W'(s_data.axis);

    always_comb begin
        s_ready             = !q_stat.full;
        q_wr_en             = s_valid && !q_stat.full;
        q_wr_data.capture   = (s_data.req_type == ECE_REQ_CAPTURE);
        // axis must be below both the fitted count and the storage depth
        q_wr_data.axis_ok   = (axis_wide < ECE_CMP_W'(axes_present_reg))
                              && (axis_wide < ECE_CMP_W'(AXES));
        q_wr_data.axis      = s_data.axis;
        q_wr_data.raw_count = s_data.raw_count;
    end

endmodule

`default_nettype wire

// File: rtl/core/ece_queue.sv
// ece_queue: short register queue of classified items between front and back
// depends on: ece_pkg
`default_nettype none

module ece_queue
    import ece_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_en,
    input  wire ece_cmd_t wr_data,
    input  wire logic     rd_en,
    output ece_cmd_t      rd_data,
    output ece_q_stat_t   stat
);

    ece_cmd_t               q_mem [ECE_Q_DEPTH];
    logic [ECE_Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ECE_Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ECE_Q_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr, do_rd;

    assign stat.full      = (count_reg == ECE_Q_CNT_W'(ECE_Q_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign do_wr          = wr_en && !stat.full;
    assign do_rd          = rd_en && stat.not_empty;
    assign rd_data        = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == ECE_Q_PTR_W'(ECE_Q_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == ECE_Q_PTR_W'(ECE_Q_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ece_back.sv
// ece_back: per-axis high byte tracking, home capture and the result register
// depends on: ece_pkg
`default_nettype none

module ece_back
    import ece_pkg::*;
#(
    parameter int AXES = ECE_AXES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ece_q_stat_t q_stat,
    input  wire ece_cmd_t    q_rd_data,
    output logic             q_rd_en,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ece_out_t         m_data
);

    logic [1:0]            top_reg  [AXES];
    logic [ECE_HIGH_W-1:0] high_reg [AXES];
    logic [ECE_EXT_W-1:0]  home_reg [AXES];

    logic                  out_valid_reg;
    ece_out_t              out_data_reg, out_data_next;

    logic                  pop;
    logic [1:0]            old_top, new_top;
    logic [ECE_HIGH_W-1:0] old_high, high_next;
    logic [ECE_EXT_W-1:0]  old_home, ext_count;
    logic [AXES-1:0]       sel;

    assign pop     = q_stat.not_empty && (!out_valid_reg || m_ready);
    assign q_rd_en = pop;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // select the state of the addressed axis
    always_comb begin
        old_top  = '0;
        old_high = '0;
        old_home = '0;
        for (int k = 0; k < AXES; k++) begin
            sel[k] = (ECE_CMP_W'(q_rd_data.axis) == ECE_CMP_W'(k));
            if (sel[k]) begin
                old_top  = top_reg[k];
                old_high = high_reg[k];
                old_home = home_reg[k];
            end
        end
    end

    always_comb begin
        new_top = q_rd_data.raw_count[ECE_RAW_W-1 -: 2];
        if (old_top == ECE_TOP_HIGH && new_top == ECE_TOP_LOW) begin
            high_next = old_high + 1'b1;
        end else if (old_top == ECE_TOP_LOW && new_top == ECE_TOP_HIGH) begin
            high_next = old_high - 1'b1;
        end else begin
            high_next = old_high;
        end
        ext_count = {high_next, q_rd_data.raw_count};

        out_data_next.axis_out   = q_rd_data.axis;
        out_data_next.axis_valid = q_rd_data.axis_ok;
        if (!q_rd_data.axis_ok || q_rd_data.capture) begin
            out_data_next.position = '0;
        end else begin
            out_data_next.position = ext_count - old_home;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < AXES; k++) begin
                top_reg[k]  <= '0;
                high_reg[k] <= '0;
                home_reg[k] <= '0;
            end
        end else if (pop && q_rd_data.axis_ok) begin
            for (int k = 0; k < AXES; k++) begin
                if (sel[k]) begin
                    top_reg[k]  <= new_top;
                    high_reg[k] <= high_next;
                    if (q_rd_data.capture) begin
                        home_reg[k] <= ext_count;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/encoder_count_extender_top.sv
// encoder_count_extender_top: top level of the encoder count extender
// depends on: ece_pkg, ece_front, ece_queue, ece_back
//
// usage
// - s_ channel: one item per encoder reading, with request type (read or
//   read and capture home), axis number and the raw 24-bit counter value
// - m_ channel: exactly one result item per input item, in order: the
//   32-bit extended count minus the axis home position, an axis-valid flag
//   and the axis number
// - cfg_we / cfg_wdata: writes axes_present (reset 8); axes at or beyond it,
//   or beyond the AXES storage depth, give axis_valid 0 and position 0 and
//   leave the axis state untouched; write only while the block is idle
// - path: an accepted item is written to a queue slot and then, when the
//   result side is free, to the result register
// - throughput: one item per cycle while m_ready stays high; the per-axis
//   read-modify-write in the back stage writes the state back when the item
//   is taken, so items for the same axis can follow each other directly
// - a two-entry queue sits between the classifying front and the back;
//   when m_ready is low the result register holds, the queue fills and
//   s_ready falls once it is full
// - reset (synchronous, aresetn low) empties the queue, clears m_valid,
//   all per-axis top bits, high bytes and home positions, and sets
//   axes_present to 8
`default_nettype none

module encoder_count_extender_top
    import ece_pkg::*;
#(
    parameter int AXES = ECE_AXES_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [ECE_CFG_W-1:0] cfg_wdata,
    // input items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ece_in_t              s_data,
    // result items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ece_out_t                  m_data
);

    // front to queue
    logic        q_wr_en;
    ece_cmd_t    q_wr_data;
    // queue to back
    logic        q_rd_en;
    ece_cmd_t    q_rd_data;
    ece_q_stat_t q_stat;

    // front: config register, acceptance and axis range check
    ece_front #(
        .AXES (AXES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    // decoupling queue, lets either side stall on its own
    ece_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // back: width extension, home capture and the result register
    ece_back #(
        .AXES (AXES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_rd_data (q_rd_data),
        .q_rd_en   (q_rd_en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: rtl/core/ece_checker.sv
// ece_checker: port-level checks on the encoder count extender, bound to the top
// depends on: ece_pkg, encoder_count_extender_top
`default_nettype none

module ece_checker
    import ece_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire ece_out_t             m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // rejected axes report a zero position
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.axis_valid |-> m_data.position == '0)
        else $error("rejected axis with nonzero position");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted item goes through its queue slot and makes the result side valid
    a_item_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("accepted item did not reach the result register");

endmodule

bind encoder_count_extender_top ece_checker u_ece_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for encoder_count_extender_top, with a scoreboard class
// that predicts the extended positions; depends on ece_pkg and the block's rtl

module tb;
    import ece_pkg::*;

    localparam int AXIS_SLOTS     = ECE_AXES_DEFAULT;
    localparam int HOLD_CYCLES    = 150;    // long result-side hold-off, fills the queue
    localparam int SETTLE_CYCLES  = 4;      // idle margin before a register write and before the end
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake on either side
    localparam int REPORT_CAP     = 50;     // mismatch lines printed at most

    // pressure applied during a random phase
    typedef enum int {PH_PLAIN, PH_HOLD, PH_PAUSE, PH_BURST} phase_kind_t;

    // predicts one position item per reading and checks results in order
    class position_scoreboard;
        logic [1:0]            top_seen  [AXIS_SLOTS];
        logic [ECE_HIGH_W-1:0] high_byte [AXIS_SLOTS];
        logic [ECE_EXT_W-1:0]  home_pos  [AXIS_SLOTS];
        logic [ECE_CFG_W-1:0]  axes_fitted;
        ece_out_t              expected_q[$];
        int                    errors, readings, captures, rejects, carries, checked;

        function new();
            axes_fitted = ECE_AXES_PRESENT_RST;
            for (int k = 0; k < AXIS_SLOTS; k++) begin
                top_seen[k]  = ECE_TOP_LOW;
                high_byte[k] = '0;
                home_pos[k]  = '0;
            end
        endfunction

        function void note_item(ece_in_t it);
            ece_out_t             exp;
            logic [1:0]           top;
            logic [ECE_EXT_W-1:0] ext;
            int                   ax;
            ax             = it.axis;
            readings++;
            exp.axis_out   = it.axis;
            exp.axis_valid = 1'b0;
            exp.position   = '0;
            if (ax < axes_fitted && ax < AXIS_SLOTS) begin
                top = it.raw_count[ECE_RAW_W-1 -: 2];
                if (top_seen[ax] == ECE_TOP_HIGH && top == ECE_TOP_LOW) begin
                    high_byte[ax] = high_byte[ax] + 1'b1;
                    carries++;
                end else if (top_seen[ax] == ECE_TOP_LOW && top == ECE_TOP_HIGH) begin
                    high_byte[ax] = high_byte[ax] - 1'b1;
                    carries++;
                end
                top_seen[ax] = top;
                ext = {high_byte[ax], it.raw_count};
                if (it.req_type == ECE_REQ_CAPTURE) begin
                    home_pos[ax] = ext;
                    captures++;
                end
                exp.position   = ext - home_pos[ax];
                exp.axis_valid = 1'b1;
            end else begin
                rejects++;
            end
            expected_q.push_back(exp);
        endfunction

        task check_result(ece_out_t got);
            ece_out_t exp;
            if (expected_q.size() == 0) begin
                report("result with nothing expected", got, got);
            end else begin
                exp = expected_q.pop_front();
                checked++;
                if (got.axis_out !== exp.axis_out)
                    report("axis_out", got, exp);
                if (got.axis_valid !== exp.axis_valid)
                    report("axis_valid", got, exp);
                if (got.position !== exp.position)
                    report("position", got, exp);
            end
        endtask

        task flush_leftovers();
            ece_out_t exp;
            while (expected_q.size() != 0) begin
                exp = expected_q.pop_front();
                report("expected result never came", '0, exp);
            end
        endtask

        task report(string what, ece_out_t got, ece_out_t exp);
            errors++;
            if (errors <= REPORT_CAP)
                $display("mismatch %0t result %0d %s: got pos %h ok %b axis %0d, want pos %h ok %b axis %0d",
                         $time, checked, what, got.position, got.axis_valid, got.axis_out,
                         exp.position, exp.axis_valid, exp.axis_out);
        endtask

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [ECE_CFG_W-1:0] cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    ece_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    ece_out_t             m_data;

    position_scoreboard   sb;
    logic [1:0]           stim_top [AXIS_SLOTS];   // shapes the stimulus only
    int                   holds_asked  = 0;
    bit                   no_idle      = 1'b0;
    int                   quiet_cycles = 0;
    int                   input_stalls = 0;

    encoder_count_extender_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // a reading that mostly walks the counter through its quadrants, with
    // plenty of direct 11/00 jumps so the high byte moves both ways
    function automatic ece_in_t random_item(int fitted);
        ece_in_t    it;
        int         ax, r, reach;
        logic [1:0] top;
        reach = (fitted > AXIS_SLOTS) ? AXIS_SLOTS : fitted;
        if (reach > 0 && $urandom_range(0, 99) < 85)
            ax = $urandom_range(0, reach - 1);
        else
            ax = $urandom_range(0, AXIS_SLOTS - 1);
        top = stim_top[ax];
        r   = $urandom_range(0, 99);
        if (r < 30)
            top = top + 2'd1;
        else if (r < 50)
            top = top - 2'd1;
        else if (r < 65)
            top = stim_top[ax];
        else if (r < 85)
            top = (top == ECE_TOP_HIGH) ? ECE_TOP_LOW : ECE_TOP_HIGH;
        else
            top = 2'($urandom);
        stim_top[ax] = top;
        it.req_type  = ($urandom_range(0, 99) < 12) ? ECE_REQ_CAPTURE : ECE_REQ_READ;
        it.axis      = ax[ECE_AXIS_W-1:0];
        it.raw_count = {top, 22'($urandom)};
        return it;
    endfunction

    // offer one item, hold it until taken, then maybe idle
    task send_item(ece_in_t it);
        int g;
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        g = no_idle ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task send_reading(logic req, int ax, logic [ECE_RAW_W-1:0] raw);
        ece_in_t it;
        it.req_type  = req;
        it.axis      = ax[ECE_AXIS_W-1:0];
        it.raw_count = raw;
        send_item(it);
    endtask

    // stop offering and wait for every outstanding result
    task wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    // register write, only ever with the block idle
    task write_axes(int fitted);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fitted[ECE_CFG_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task run_phase(int fitted, int n, phase_kind_t kind);
        write_axes(fitted);
        for (int i = 0; i < n; i++) begin
            if (kind == PH_HOLD && i == n / 3)
                holds_asked++;
            if (kind == PH_PAUSE && i == n / 2)
                wait_for_results();
            no_idle = (kind == PH_BURST && i < 80);
            send_item(random_item(fitted));
        end
        no_idle = 1'b0;
    endtask

    // sampling at the edge sees the values from before it, so the order of
    // processes inside a time step does not matter
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                sb.axes_fitted = cfg_wdata;
            if (s_valid && s_ready)
                sb.note_item(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && !s_ready)
                input_stalls++;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                    $display("encoder_count_extender_top regression: fail");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls, plus the long hold-offs the driver asks for
    initial begin
        int holds_served;
        holds_served = 0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (holds_served != holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (no_idle || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        int          phase_axes [6];
        int          phase_len  [6];
        phase_kind_t phase_kind [6];
        phase_axes = '{15, 0, 1, 5, 8, 3};
        phase_len  = '{320, 120, 260, 320, 400, 270};
        phase_kind = '{PH_HOLD, PH_PLAIN, PH_PAUSE, PH_BURST, PH_HOLD, PH_PAUSE};
        sb = new();
        for (int k = 0; k < AXIS_SLOTS; k++)
            stim_top[k] = ECE_TOP_LOW;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: quadrant moves, high byte wrapping both ways, capture
        send_reading(ECE_REQ_READ,    0, 24'h000000);
        send_reading(ECE_REQ_READ,    0, 24'hC00000);   // 00 to 11, byte wraps down
        send_reading(ECE_REQ_READ,    0, 24'h000000);   // 11 to 00, byte wraps up
        send_reading(ECE_REQ_READ,    0, 24'h3FFFFF);
        send_reading(ECE_REQ_READ,    0, 24'h400000);   // 00 to 01, no carry
        send_reading(ECE_REQ_READ,    0, 24'h800000);   // 01 to 10
        send_reading(ECE_REQ_READ,    0, 24'hC00000);   // 10 to 11
        send_reading(ECE_REQ_READ,    0, 24'h000001);   // carry into the high byte
        send_reading(ECE_REQ_CAPTURE, 0, 24'h123456);   // new home, reads zero
        send_reading(ECE_REQ_READ,    0, 24'h123455);   // one count below home
        send_reading(ECE_REQ_READ,    7, 24'hFFFFFF);
        send_reading(ECE_REQ_CAPTURE, 7, 24'hFFFFFF);
        send_reading(ECE_REQ_READ,    7, 24'h000000);   // wraps past home
        send_reading(ECE_REQ_CAPTURE, 3, 24'hC00000);   // capture straight after a borrow
        send_reading(ECE_REQ_READ,    3, 24'hBFFFFF);
        send_reading(ECE_REQ_READ,    5, 24'h555555);
        send_reading(ECE_REQ_READ,    6, 24'hAAAAAA);

        // random phases: above the axis count, none fitted, one, some, all
        for (int p = 0; p < 6; p++)
            run_phase(phase_axes[p], phase_len[p], phase_kind[p]);

        wait_for_results();
        repeat (SETTLE_CYCLES * 3) @(posedge aclk);
        sb.flush_leftovers();
        $display("covered %0d readings: %0d captures, %0d rejected, %0d high-byte carries",
                 sb.readings, sb.captures, sb.rejects, sb.carries);
        $display("checked %0d results, input stalled %0d cycles, axis counts 0 to 15",
                 sb.checked, input_stalls);
        if (sb.errors == 0)
            $display("encoder_count_extender_top regression: pass");
        else
            $display("encoder_count_extender_top regression: fail");
        $finish;
    end

endmodule

// File: encoder_count_extender_top.f
rtl/core/ece_pkg.sv
rtl/core/ece_front.sv
rtl/core/ece_queue.sv
rtl/core/ece_back.sv
rtl/core/encoder_count_extender_top.sv
rtl/core/ece_checker.sv
tb/tb.sv
